/* rtl/argtok_pkg.sv */
// Package with the character codes, widths and result type of the argument tokenizer.
`default_nettype none

package argtok_pkg;

    // Width of the saturating argument counter.
    localparam int COUNT_WIDTH = 16;

    // Widths of the result fields.
    localparam int BYTE_WIDTH  = 8;
    localparam int TOTAL_WIDTH = 16;
    localparam int TOTAL_MAX   = (1 << TOTAL_WIDTH) - 1;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_VT        = 8'h0B;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [BYTE_WIDTH-1:0]  out_byte;
        logic                   end_of_arg;
        logic                   buffer_done;
        logic [TOTAL_WIDTH-1:0] arg_total;
        logic                   last_of_run;
    } t_result;

endpackage

`default_nettype wire

/* rtl/argument_tokenizer.sv */
// Argument tokenizer: splits a zero-terminated text byte stream into argument bytes and end marks.
// An accepted byte passes from the input register through one pass of the scan logic into the
// result queue, whose head is offered on m_axis.
// Throughput: one byte per cycle while the queue has room for two results; a byte with two
// results takes a second output transfer, absorbed by the four-entry queue or an input stall.
// Reset: i_rst_n is synchronous and active low; it empties the input register and the result
// queue and returns the scanner to between-arguments with a zero argument count.
`default_nettype none

module argument_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] arg_total
    output logic [1:0]       m_axis_tuser,   // [0] end_of_arg, [1] buffer_done
    output logic             m_axis_tlast    // last_of_run
);

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_PLAIN   = 2'd1,
        MODE_QUOTED  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_mode;

    localparam int CW = argtok_pkg::COUNT_WIDTH;

    // Input register.
    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;

    // Scanner state.
    t_mode                             r_mode, n_mode;
    logic                              r_qsingle, n_qsingle;
    logic                              r_esc, n_esc;
    logic [CW-1:0]                     r_cnt, n_cnt;

    // Result queue.
    argtok_pkg::t_result               r_queue [argtok_pkg::QUEUE_DEPTH];
    logic [argtok_pkg::QPTR_WIDTH-1:0] r_wr_ptr, r_rd_ptr;
    logic [argtok_pkg::QCNT_WIDTH-1:0] r_qcount;

    // Scan pass signals.
    logic                              proc;
    logic                              pop;
    logic                              pre_bs;
    logic                              esc_hit;
    logic                              m_valid;
    logic [7:0]                        m_byte;
    logic                              m_eoa;
    logic                              m_done;
    logic                              finished;
    logic [CW-1:0]                     cnt_upd;
    logic [31:0]                       old_ext, upd_ext;
    logic [argtok_pkg::TOTAL_WIDTH-1:0] total_old, total_upd;
    logic                              is_space;
    logic                              is_escapable;
    logic [7:0]                        close_quote;
    argtok_pkg::t_result               res0, res1;
    logic [1:0]                        push_n;

    // Character classes of the registered byte.
    always_comb begin
        is_space = (r_in_byte == argtok_pkg::CH_SPACE) || (r_in_byte == argtok_pkg::CH_TAB)
                || (r_in_byte == argtok_pkg::CH_FF)    || (r_in_byte == argtok_pkg::CH_VT)
                || (r_in_byte == argtok_pkg::CH_LF)    || (r_in_byte == argtok_pkg::CH_CR);
        is_escapable = (r_in_byte == argtok_pkg::CH_DQUOTE)
                    || (r_in_byte == argtok_pkg::CH_SQUOTE)
                    || (r_in_byte == argtok_pkg::CH_BACKSLASH);
        close_quote = r_qsingle ? argtok_pkg::CH_SQUOTE : argtok_pkg::CH_DQUOTE;
    end

    // The scan logic runs when the queue has room for two results.
    assign proc          = r_in_valid
                        && (r_qcount <= argtok_pkg::QCNT_WIDTH'(argtok_pkg::QUEUE_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || proc;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Next scanner state and the results of one byte.
    always_comb begin
        n_mode    = r_mode;
        n_qsingle = r_qsingle;
        n_esc     = r_esc;
        cnt_upd   = r_cnt;
        pre_bs    = 1'b0;
        esc_hit   = 1'b0;
        m_valid   = 1'b0;
        m_byte    = r_in_byte;
        m_eoa     = 1'b0;
        m_done    = 1'b0;
        finished  = 1'b0;

        // A pending backslash either escapes this byte or is emitted on its own.
        if (r_esc) begin
            n_esc = 1'b0;
            if (is_escapable) begin
                esc_hit = 1'b1;
                m_valid = 1'b1;
            end else begin
                pre_bs = 1'b1;
            end
        end

        if (!esc_hit) begin
            case (r_mode)
                MODE_BETWEEN: begin
                    if (r_in_byte == argtok_pkg::CH_NUL) begin
                        m_valid  = 1'b1;
                        m_byte   = argtok_pkg::CH_NUL;
                        m_done   = 1'b1;
                        finished = 1'b1;
                    end else if (is_space) begin
                        n_mode = MODE_BETWEEN;
                    end else if ((r_in_byte == argtok_pkg::CH_SEMICOLON)
                              || (r_in_byte == argtok_pkg::CH_HASH)) begin
                        n_mode = MODE_COMMENT;
                    end else if ((r_in_byte == argtok_pkg::CH_DQUOTE)
                              || (r_in_byte == argtok_pkg::CH_SQUOTE)) begin
                        n_mode    = MODE_QUOTED;
                        n_qsingle = (r_in_byte == argtok_pkg::CH_SQUOTE);
                    end else begin
                        n_mode = MODE_PLAIN;
                        if (r_in_byte == argtok_pkg::CH_BACKSLASH) begin
                            n_esc = 1'b1;
                        end else begin
                            m_valid = 1'b1;
                        end
                    end
                end
                MODE_PLAIN, MODE_QUOTED: begin
                    if ((r_in_byte == argtok_pkg::CH_NUL)
                        || ((r_mode == MODE_PLAIN) && is_space)
                        || ((r_mode == MODE_QUOTED)
                            && ((r_in_byte == argtok_pkg::CH_LF)
                                || (r_in_byte == argtok_pkg::CH_CR)
                                || (r_in_byte == close_quote)))) begin
                        // Close the argument, with end of buffer on a zero byte.
                        if (r_cnt != {CW{1'b1}}) begin
                            cnt_upd = r_cnt + CW'(1);
                        end
                        m_valid  = 1'b1;
                        m_byte   = argtok_pkg::CH_NUL;
                        m_eoa    = 1'b1;
                        m_done   = (r_in_byte == argtok_pkg::CH_NUL);
                        finished = (r_in_byte == argtok_pkg::CH_NUL);
                        n_mode   = MODE_BETWEEN;
                    end else if (r_in_byte == argtok_pkg::CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        m_valid = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (r_in_byte == argtok_pkg::CH_NUL) begin
                        m_valid  = 1'b1;
                        m_byte   = argtok_pkg::CH_NUL;
                        m_done   = 1'b1;
                        finished = 1'b1;
                    end else if (r_in_byte == argtok_pkg::CH_LF) begin
                        n_mode = MODE_BETWEEN;
                    end
                end
                default: begin
                    n_mode = MODE_BETWEEN;
                end
            endcase
        end

        // End of buffer returns the scanner state to the reset values.
        n_cnt = cnt_upd;
        if (finished) begin
            n_mode    = MODE_BETWEEN;
            n_qsingle = 1'b0;
            n_esc     = 1'b0;
            n_cnt     = '0;
        end
    end

    // Reported totals, clipped to the field width.
    always_comb begin
        old_ext   = 32'(r_cnt);
        upd_ext   = 32'(cnt_upd);
        total_old = (old_ext > 32'(argtok_pkg::TOTAL_MAX)) ?
                    argtok_pkg::TOTAL_WIDTH'(argtok_pkg::TOTAL_MAX) : old_ext[15:0];
        total_upd = (upd_ext > 32'(argtok_pkg::TOTAL_MAX)) ?
                    argtok_pkg::TOTAL_WIDTH'(argtok_pkg::TOTAL_MAX) : upd_ext[15:0];
    end

    // Arrange up to two results in order: the kept backslash comes first.
    always_comb begin
        res1.out_byte    = m_byte;
        res1.end_of_arg  = m_eoa;
        res1.buffer_done = m_done;
        res1.arg_total   = total_upd;
        res1.last_of_run = 1'b1;
        if (pre_bs) begin
            res0.out_byte    = argtok_pkg::CH_BACKSLASH;
            res0.end_of_arg  = 1'b0;
            res0.buffer_done = 1'b0;
            res0.arg_total   = total_old;
            res0.last_of_run = !m_valid;
        end else begin
            res0 = res1;
        end
        push_n = proc ? (2'(pre_bs) + 2'(m_valid)) : 2'd0;
    end

    // Input register, scanner state and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_BETWEEN;
            r_qsingle  <= 1'b0;
            r_esc      <= 1'b0;
            r_cnt      <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_qcount   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc) begin
                r_mode    <= n_mode;
                r_qsingle <= n_qsingle;
                r_esc     <= n_esc;
                r_cnt     <= n_cnt;
            end
            r_wr_ptr <= r_wr_ptr + argtok_pkg::QPTR_WIDTH'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + argtok_pkg::QPTR_WIDTH'(1);
            end
            r_qcount <= r_qcount + argtok_pkg::QCNT_WIDTH'(push_n)
                      - argtok_pkg::QCNT_WIDTH'(pop);
        end
    end

    // Payload registers: input byte and queue entries.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + argtok_pkg::QPTR_WIDTH'(1)] <= res1;
        end
    end

    // Result stream from the head of the queue.
    assign m_axis_tvalid = (r_qcount != '0);
    assign m_axis_tdata  = {r_queue[r_rd_ptr].arg_total, r_queue[r_rd_ptr].out_byte};
    assign m_axis_tuser  = {r_queue[r_rd_ptr].buffer_done, r_queue[r_rd_ptr].end_of_arg};
    assign m_axis_tlast  = r_queue[r_rd_ptr].last_of_run;

    // The queue never holds more entries than it has.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= argtok_pkg::QCNT_WIDTH'(argtok_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A registered byte that is not scanned stays for the next cycle.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("registered input byte lost");

    // An escape is pending only inside an argument.
    a_esc_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> ((r_mode == MODE_PLAIN) || (r_mode == MODE_QUOTED)))
        else $error("escape pending outside an argument");

    // End of buffer clears the scanner.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && finished) |=> ((r_mode == MODE_BETWEEN) && (r_cnt == '0) && !r_esc))
        else $error("scanner not cleared after end of buffer");

    // A byte that pushes two results finds room for both in the queue.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2) |-> (r_qcount <= argtok_pkg::QCNT_WIDTH'(argtok_pkg::QUEUE_DEPTH - 2)))
        else $error("double push without room");

endmodule

`default_nettype wire

/* tb/sv/argument_tokenizer_tb.sv */
// Self-checking testbench for the argument tokenizer stream block.
`timescale 1ns / 100ps

module argument_tokenizer_tb;
    import argtok_pkg::*;

    // Scan modes of the tokenizer as the predictor tracks them.
    typedef enum logic [1:0] {
        SCAN_BETWEEN,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_COMMENT
    } scan_mode_e;

    // Predicts the argument stream and checks every result transfer against it.
    class token_scoreboard;
        t_result         expected_q[$];
        scan_mode_e      mode;
        bit              single_quote;
        bit              escaped;
        longint unsigned closed_args;
        int              errors;
        int              bytes_in;
        int              busy_bytes;
        int              results_out;
        int              buffers_out;

        function new();
            clear();
            errors      = 0;
            bytes_in    = 0;
            busy_bytes  = 0;
            results_out = 0;
            buffers_out = 0;
        endfunction

        static function bit is_blank(logic [7:0] b);
            return b == CH_SPACE || b == CH_TAB || b == CH_FF || b == CH_VT ||
                   b == CH_LF || b == CH_CR;
        endfunction

        function void clear();
            mode         = SCAN_BETWEEN;
            single_quote = 1'b0;
            escaped      = 1'b0;
            closed_args  = 0;
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        function void expect_result(logic [7:0] b, bit eoa, bit done);
            t_result r;
            r.out_byte    = b;
            r.end_of_arg  = eoa;
            r.buffer_done = done;
            r.arg_total   = (closed_args > TOTAL_MAX) ? TOTAL_WIDTH'(TOTAL_MAX)
                                                      : TOTAL_WIDTH'(closed_args);
            r.last_of_run = 1'b0;
            expected_q.push_back(r);
        endfunction

        // Closing an argument bumps the saturating count before the end mark is formed.
        function void close_arg(bit done);
            longint unsigned ceiling;
            ceiling = (longint'(1) << COUNT_WIDTH) - 1;
            if (closed_args < ceiling)
                closed_args++;
            expect_result(CH_NUL, 1'b1, done);
            mode = SCAN_BETWEEN;
        endfunction

        function void argument_byte(logic [7:0] b);
            if (b == CH_BACKSLASH)
                escaped = 1'b1;
            else
                expect_result(b, 1'b0, 1'b0);
        endfunction

        // Works out the results that one accepted text byte causes.
        function void note_input(logic [7:0] b);
            int  first;
            bit  done;
            bit  ignored;
            logic [7:0] closer;
            first   = expected_q.size();
            done    = 1'b0;
            ignored = 1'b0;
            bytes_in++;

            // A pending backslash either escapes this byte or is emitted as it stands.
            if (escaped) begin
                escaped = 1'b0;
                if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BACKSLASH) begin
                    expect_result(b, 1'b0, 1'b0);
                    expected_q[expected_q.size() - 1].last_of_run = 1'b1;
                    busy_bytes++;
                    return;
                end
                expect_result(CH_BACKSLASH, 1'b0, 1'b0);
            end

            closer = single_quote ? CH_SQUOTE : CH_DQUOTE;
            case (mode)
                SCAN_BETWEEN: begin
                    if (b == CH_NUL) begin
                        expect_result(CH_NUL, 1'b0, 1'b1);
                        done = 1'b1;
                    end else if (is_blank(b)) begin
                        ignored = 1'b1;
                    end else if (b == CH_SEMICOLON || b == CH_HASH) begin
                        mode = SCAN_COMMENT;
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        mode         = SCAN_QUOTED;
                        single_quote = (b == CH_SQUOTE);
                    end else begin
                        mode = SCAN_PLAIN;
                        argument_byte(b);
                    end
                end
                SCAN_PLAIN: begin
                    if (b == CH_NUL) begin
                        close_arg(1'b1);
                        done = 1'b1;
                    end else if (is_blank(b)) begin
                        close_arg(1'b0);
                    end else begin
                        argument_byte(b);
                    end
                end
                SCAN_QUOTED: begin
                    if (b == CH_NUL) begin
                        close_arg(1'b1);
                        done = 1'b1;
                    end else if (b == CH_LF || b == CH_CR || b == closer) begin
                        close_arg(1'b0);
                    end else begin
                        argument_byte(b);
                    end
                end
                default: begin
                    if (b == CH_NUL) begin
                        expect_result(CH_NUL, 1'b0, 1'b1);
                        done = 1'b1;
                    end else if (b == CH_LF) begin
                        mode = SCAN_BETWEEN;
                    end else begin
                        ignored = 1'b1;
                    end
                end
            endcase

            if (done)
                clear();
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last_of_run = 1'b1;
            if (!ignored)
                busy_bytes++;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compares one result transfer field by field with the oldest prediction.
        task check_result(t_result got);
            t_result want;
            results_out++;
            if (got.buffer_done === 1'b1)
                buffers_out++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing predicted (byte %02h)",
                                 results_out, got.out_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("result %0d out_byte %02h, predicted %02h",
                                 results_out, got.out_byte, want.out_byte));
            if (got.end_of_arg !== want.end_of_arg)
                report($sformatf("result %0d end_of_arg %b, predicted %b",
                                 results_out, got.end_of_arg, want.end_of_arg));
            if (got.buffer_done !== want.buffer_done)
                report($sformatf("result %0d buffer_done %b, predicted %b",
                                 results_out, got.buffer_done, want.buffer_done));
            if (got.arg_total !== want.arg_total)
                report($sformatf("result %0d arg_total %0d, predicted %0d",
                                 results_out, got.arg_total, want.arg_total));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("result %0d last_of_run %b, predicted %b",
                                 results_out, got.last_of_run, want.last_of_run));
        endtask

        task report_leftovers();
            if (expected_q.size() != 0)
                report($sformatf("%0d predicted results never arrived", expected_q.size()));
        endtask
    endclass

    // Short directed text: extreme bytes, quoting, escapes, comments and zero bytes.
    localparam int DIRECTED_LEN = 35;
    localparam logic [7:0] DIRECTED_TEXT [DIRECTED_LEN] = '{
        CH_NUL,
        8'hFF, 8'h01, CH_SPACE,
        CH_SQUOTE, CH_SQUOTE, CH_TAB,
        CH_DQUOTE, 8'h78, CH_DQUOTE, CH_DQUOTE, 8'h79, CH_CR,
        CH_BACKSLASH, CH_DQUOTE, CH_BACKSLASH, 8'h71, CH_BACKSLASH, CH_BACKSLASH, CH_FF,
        CH_SEMICOLON, 8'h61, CH_LF, CH_HASH, CH_NUL,
        CH_SQUOTE, 8'h61, CH_LF, CH_DQUOTE, 8'h62, CH_NUL,
        CH_VT, 8'h61, CH_BACKSLASH, CH_NUL
    };
    localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_FF, CH_VT, CH_LF, CH_CR};

    // Idle percentages per phase: none, sender only, receiver only, both.
    localparam int PHASES = 4;
    localparam int GAP_PCT   [PHASES] = '{0, 45, 0, 19};
    localparam int STALL_PCT [PHASES] = '{0, 0, 45, 19};
    localparam int PHASE_BYTES = 240;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] out_byte, [23:8] arg_total
    logic [1:0]  m_axis_tuser;            // [0] end_of_arg, [1] buffer_done
    logic        m_axis_tlast;            // last_of_run

    logic        hold_off  = 1'b0;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    logic [7:0]  text_q[$];
    t_result     observed;
    token_scoreboard sb = new();

    argument_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver back-pressure, forced low for the whole of a hold-off.
    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Both stream ports are watched here, inputs first, so predictions lead results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                observed.out_byte    = m_axis_tdata[7:0];
                observed.arg_total   = m_axis_tdata[23:8];
                observed.end_of_arg  = m_axis_tuser[0];
                observed.buffer_done = m_axis_tuser[1];
                observed.last_of_run = m_axis_tlast;
                sb.check_result(observed);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] rand_ink();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255, 1));
        while (token_scoreboard::is_blank(b));
        return b;
    endfunction

    // Opening byte of a plain word: any non-zero, non-blank byte that does not start a quote or a comment.
    function automatic logic [7:0] plain_start();
        logic [7:0] b;
        do
            b = rand_ink();
        while (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_SEMICOLON || b == CH_HASH);
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        case ($urandom_range(7))
            0: return CH_SPACE;
            1: return CH_BACKSLASH;
            2: return CH_SQUOTE;
            3: return CH_DQUOTE;
            default: return rand_ink();
        endcase
    endfunction

    function automatic logic [7:0] escape_target();
        case ($urandom_range(5))
            0: return CH_DQUOTE;
            1: return CH_SQUOTE;
            2: return CH_BACKSLASH;
            3: return BLANKS[$urandom_range(5)];
            default: return rand_ink();
        endcase
    endfunction

    // Builds one command line of random tokens, mostly well formed, ending with a zero byte or a line feed.
    task automatic compose_line();
        logic [7:0] quote;
        repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    text_q.push_back(plain_start());
                    repeat ($urandom_range(5))
                        text_q.push_back(($urandom_range(5) == 0) ? CH_BACKSLASH : rand_ink());
                end
                4, 5, 6: begin
                    quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                    text_q.push_back(quote);
                    repeat ($urandom_range(5))
                        text_q.push_back(quoted_byte());
                    case ($urandom_range(5))
                        0: text_q.push_back(CH_CR);
                        1: text_q.push_back(CH_LF);
                        default: text_q.push_back(quote);
                    endcase
                end
                7: begin
                    text_q.push_back($urandom_range(1) ? CH_SEMICOLON : CH_HASH);
                    repeat ($urandom_range(4))
                        text_q.push_back($urandom_range(3) ? rand_ink() : CH_SPACE);
                    text_q.push_back(CH_LF);
                end
                8: begin
                    repeat ($urandom_range(4, 1))
                        text_q.push_back(8'($urandom_range(255, 1)));
                end
                default: begin
                    text_q.push_back(plain_start());
                    repeat ($urandom_range(3, 1)) begin
                        text_q.push_back(CH_BACKSLASH);
                        text_q.push_back(escape_target());
                    end
                end
            endcase
            repeat ($urandom_range(2, 1))
                text_q.push_back(BLANKS[$urandom_range(5)]);
        end
        text_q.push_back($urandom_range(3) ? CH_NUL : CH_LF);
    endtask

    // Offers one byte, after an optional sender gap, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = $urandom_range(3, 1);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
    endtask

    // Sender stands idle until every predicted result has arrived or a spin limit runs out, then settles.
    task automatic wait_drained(input int settle);
        int spins;
        spins = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0 && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Main sequence: reset, directed text, then random phases.
    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_TEXT[k])
            send_byte(DIRECTED_TEXT[k]);
        wait_drained(8);

        for (int p = 0; p < PHASES; p++) begin
            gap_pct   = GAP_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == 0) begin
                // Long receiver hold-off while a word keeps arriving, so the input stalls.
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                join_none
                repeat (40)
                    send_byte(8'(8'h61 + $urandom_range(25)));
                send_byte(CH_NUL);
            end
            target = sb.bytes_in + PHASE_BYTES;
            while (sb.bytes_in < target) begin
                compose_line();
                send_text();
            end
            send_byte(CH_NUL);
            wait_drained(8);
        end

        wait_drained(16);
        sb.report_leftovers();
        $display("Run covered %0d text bytes (%0d outside blanks and comments), %0d results,",
                 sb.bytes_in, sb.busy_bytes, sb.results_out);
        $display("and %0d ended buffers over directed, idle, stall and hold-off phases.",
                 sb.buffers_out);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
